### src/rng_pkg.sv
// Shared types and constants for the radius neighbour graph block.
`default_nettype none
package rng_pkg;

  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int RAD_W   = 42;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] REG_RADIUS = 1'b0;
  localparam logic [CFG_W-1:0] REG_COUNT  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic             valid;
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } dist_res_t;

endpackage
`default_nettype wire

### src/radius_neighbor_graph.sv
// Top level of the radius neighbour graph block: sequencer, configuration and result register.
// A load beat writes one point into the store. A query beat reads the source point,
// then the single distance unit takes one stored point per cycle through its pipeline,
// except while a hit waits for the consumer to free the result register. The scan covers
// the first N stored points, N being the count clamped to POINTS. Each neighbour within
// the radius gives one result beat in ascending index order; the final beat carries last,
// and a query with no neighbour gives a single beat with found cleared. A further beat
// is not accepted until the query has finished.
`default_nettype none
module radius_neighbor_graph import rng_pkg::*; #(
  parameter int POINTS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      action_i,
  input  wire logic [IDX_W-1:0]          point_index_i,
  input  wire logic signed [COORD_W-1:0] coord_x_i,
  input  wire logic signed [COORD_W-1:0] coord_y_i,
  input  wire logic signed [COORD_W-1:0] coord_z_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [IDX_W-1:0]               source_index_o,
  output logic [IDX_W-1:0]               neighbor_index_o,
  output logic                           found_o,
  output logic                           last_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_W-1:0]          cfg_idx_i,
  input  wire logic [RAD_W-1:0]          cfg_data_i
);

  localparam int IdxW = $clog2(POINTS);
  localparam int CntW = $clog2(POINTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SRC   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FINAL = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [RAD_W-1:0] radius_q;
  logic [CNT_W-1:0] count_q;
  logic [CntW-1:0]  count_eff;
  logic [CntW-1:0]  j_q, j_d;
  logic [IDX_W-1:0] src_idx_q, src_idx_d;
  point_t           src_q, src_d;
  logic             rd_v_q, rd_v_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic             pend_v_q, pend_v_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_src_q, out_src_d;
  logic [IDX_W-1:0] out_nb_q, out_nb_d;
  logic             out_found_q, out_found_d;
  logic             out_last_q, out_last_d;

  logic             in_accept;
  logic             src_beyond;
  logic             store_we;
  logic [IdxW-1:0]  rd_addr;
  point_t           rd_data;
  point_t           in_point;
  dist_res_t        res;
  logic             out_free;
  logic             need_push;
  logic             en;
  logic             issue;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_accept  = in_valid_i & in_ready_o;
  assign src_beyond = {1'b0, point_index_i} >= CNT_W'(POINTS);
  assign store_we   = in_accept & (action_i == ACT_LOAD) & ~src_beyond;
  assign in_point   = '{x: coord_x_i, y: coord_y_i, z: coord_z_i};

  assign count_eff = (count_q > CNT_W'(POINTS)) ? CntW'(POINTS) : CntW'(count_q);

  assign out_free  = ~out_valid_q | out_ready_i;
  assign need_push = res.valid & res.hit & pend_v_q;
  assign en        = ~need_push | out_free;
  assign issue     = j_q < count_eff;
  assign rd_addr   = (state_q == ST_IDLE) ? point_index_i[IdxW-1:0] : j_q[IdxW-1:0];

  rng_store #(
    .POINTS (POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (point_index_i[IdxW-1:0]),
    .wdata_i (in_point),
    .re_i    (en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rng_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .src_i    (src_q),
    .cand_i   (rd_data),
    .valid_i  (rd_v_q),
    .idx_i    (IDX_W'(rd_idx_q)),
    .radius_i (radius_q),
    .res_o    (res)
  );

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    src_idx_d   = src_idx_q;
    src_d       = src_q;
    rd_v_d      = rd_v_q;
    rd_idx_d    = rd_idx_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_src_d   = out_src_q;
    out_nb_d    = out_nb_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;

    if (en) begin
      rd_v_d = 1'b0;
    end

    if (en && res.valid && res.hit) begin
      if (pend_v_q) begin
        out_valid_d = 1'b1;
        out_src_d   = src_idx_q;
        out_nb_d    = IDX_W'(pend_idx_q);
        out_found_d = 1'b1;
        out_last_d  = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_idx_d = res.idx[IdxW-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && action_i == ACT_QUERY) begin
          src_idx_d = point_index_i;
          pend_v_d  = 1'b0;
          state_d   = src_beyond ? ST_FINAL : ST_SRC;
        end
      end
      ST_SRC: begin
        src_d   = rd_data;
        j_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (en && issue) begin
          rd_v_d   = j_q[IdxW-1:0] != src_idx_q[IdxW-1:0];
          rd_idx_d = j_q[IdxW-1:0];
          j_d      = j_q + CntW'(1);
        end
        if (!issue && !rd_v_q && !res.active) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_src_d   = src_idx_q;
          out_nb_d    = pend_v_q ? IDX_W'(pend_idx_q) : '0;
          out_found_d = pend_v_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      radius_q    <= RAD_W'(65536);
      count_q     <= CNT_W'(64);
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RADIUS: radius_q <= cfg_data_i;
          REG_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
          default:    radius_q <= radius_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    src_idx_q   <= src_idx_d;
    src_q       <= src_d;
    rd_idx_q    <= rd_idx_d;
    pend_idx_q  <= pend_idx_d;
    out_src_q   <= out_src_d;
    out_nb_q    <= out_nb_d;
    out_found_q <= out_found_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign source_index_o   = out_src_q;
  assign neighbor_index_o = out_nb_q;
  assign found_o          = out_found_q;
  assign last_o           = out_last_q;

  a_nofind_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_last_q)
    else $error("Result without a neighbour is not marked last.");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> j_q <= count_eff)
    else $error("Scan counter ran past the point count.");

  a_src_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> rd_idx_q != src_idx_q[IdxW-1:0])
    else $error("Source point entered the distance unit.");

  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRC |-> !pend_v_q && !res.active)
    else $error("Query started with stale pending or pipeline contents.");

endmodule
`default_nettype wire

### src/rng_store.sv
// Point store: one write port for loads and one registered read port.
`default_nettype none
module rng_store import rng_pkg::*; #(
  parameter int POINTS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [$clog2(POINTS)-1:0] waddr_i,
  input  wire point_t                    wdata_i,
  input  wire logic                      re_i,
  input  wire logic [$clog2(POINTS)-1:0] raddr_i,
  output point_t                         rdata_o
);

  point_t mem_q [POINTS];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/rng_dist.sv
// Shared squared-distance unit: difference, square, sum and radius compare in stages.
`default_nettype none
module rng_dist import rng_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire point_t           src_i,
  input  wire point_t           cand_i,
  input  wire logic             valid_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [RAD_W-1:0] radius_i,
  output dist_res_t             res_o
);

  logic signed [COORD_W-1:0] src_c [3];
  logic signed [COORD_W-1:0] cand_c [3];
  logic signed [DIFF_W-1:0]  diff [3];
  logic [DIFF_W-1:0]         abs_d [3];
  logic [DIFF_W-1:0]         abs_q [3];
  logic [SQ_W-1:0]           sq_d [3];
  logic [SQ_W-1:0]           sq_q [3];
  logic [RAD_W-1:0]          sum_d;
  logic [RAD_W-1:0]          sum_q;
  logic                      v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]          idx1_q, idx2_q, idx3_q;

  assign src_c[0]  = src_i.x;
  assign src_c[1]  = src_i.y;
  assign src_c[2]  = src_i.z;
  assign cand_c[0] = cand_i.x;
  assign cand_c[1] = cand_i.y;
  assign cand_c[2] = cand_i.z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]  = DIFF_W'(src_c[k]) - DIFF_W'(cand_c[k]);
      abs_d[k] = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
      sq_d[k]  = abs_q[k] * abs_q[k];
    end
    sum_d = RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q  <= abs_d;
      sq_q   <= sq_d;
      sum_q  <= sum_d;
      idx1_q <= idx_i;
      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
    end
  end

  assign res_o.valid  = v3_q;
  assign res_o.active = v1_q | v2_q | v3_q;
  assign res_o.hit    = sum_q <= radius_i;
  assign res_o.idx    = idx3_q;

endmodule
`default_nettype wire

### verif/tb_radius_neighbor_graph.sv
// Self-checking testbench for radius_neighbor_graph: point loads, neighbour queries, settings.
`default_nettype none
module tb_radius_neighbor_graph import rng_pkg::*;;

  localparam int POINTS      = 64;
  localparam int SETTLE      = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int COORD_MAX   = 524287;
  localparam int COORD_MIN   = -524288;
  localparam logic [RAD_W-1:0] RADIUS_MAX = {RAD_W{1'b1}};

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] nb;
    logic             found;
    logic             last;
  } link_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      action_i      = ACT_LOAD;
  logic [IDX_W-1:0]          point_index_i = '0;
  logic signed [COORD_W-1:0] coord_x_i     = '0;
  logic signed [COORD_W-1:0] coord_y_i     = '0;
  logic signed [COORD_W-1:0] coord_z_i     = '0;
  logic                      out_ready_i   = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]          cfg_idx_i     = REG_RADIUS;
  logic [RAD_W-1:0]          cfg_data_i    = '0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [IDX_W-1:0]          source_index_o;
  logic [IDX_W-1:0]          neighbor_index_o;
  logic                      found_o;
  logic                      last_o;

  point_t           point_copy [POINTS];
  logic [RAD_W-1:0] radius_copy = 42'd65536;
  logic [CNT_W-1:0] count_copy  = 7'd64;
  link_t            expected_links [$];
  int               fail_count    = 0;
  int               send_gap_pct  = 0;
  int               recv_gap_pct  = 0;
  int               centre_x      = 0;
  int               centre_y      = 0;
  int               centre_z      = 0;
  int               spread        = 256;

  radius_neighbor_graph #(.POINTS(POINTS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .point_index_i   (point_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .source_index_o  (source_index_o),
    .neighbor_index_o(neighbor_index_o),
    .found_o         (found_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
  end

  function automatic point_t mk_point(input int x, input int y, input int z);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    return p;
  endfunction

  function automatic point_t random_point();
    int     pick;
    int     k;
    point_t p;
    pick = $urandom_range(99);
    k    = $urandom_range(0, POINTS - 1);
    if (pick < 15) begin
      p = mk_point($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
                   $urandom_range(0, 20'hFFFFF));
    end else begin
      p = mk_point(centre_x + int'($urandom_range(0, 2 * spread)) - spread,
                   centre_y + int'($urandom_range(0, 2 * spread)) - spread,
                   centre_z + int'($urandom_range(0, 2 * spread)) - spread);
      if (pick < 23 && !$isunknown(point_copy[k])) begin
        p = point_copy[k];
      end
    end
    return p;
  endfunction

  function automatic longint gap_squared(input logic signed [COORD_W-1:0] a,
                                         input logic signed [COORD_W-1:0] b);
    longint g;
    g = longint'(a) - longint'(b);
    return g * g;
  endfunction

  function automatic void queue_link(input link_t link);
    expected_links = {expected_links, link};
  endfunction

  function automatic void find_neighbours(input logic act, input logic [IDX_W-1:0] idx,
                                          input point_t pt);
    int     scan;
    int     hits;
    longint sq_sum;
    point_t s;
    point_t p;
    if (act == ACT_LOAD) begin
      point_copy[idx] = pt;
      return;
    end
    scan = (count_copy > POINTS) ? POINTS : count_copy;
    s    = point_copy[idx];
    hits = 0;
    for (int j = 0; j < scan; j++) begin
      if (j == idx) continue;
      p      = point_copy[j];
      sq_sum = gap_squared(s.x, p.x) + gap_squared(s.y, p.y) + gap_squared(s.z, p.z);
      if (sq_sum <= longint'(radius_copy)) begin
        queue_link('{idx, IDX_W'(j), 1'b1, 1'b0});
        hits++;
      end
    end
    if (hits == 0) begin
      queue_link('{idx, '0, 1'b0, 1'b1});
    end else begin
      expected_links[$].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 20) begin
      $display("ERROR: %s", msg);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    link_t got;
    link_t want;
    if (out_valid_o && out_ready_i) begin
      got = '{source_index_o, neighbor_index_o, found_o, last_o};
      if (expected_links.size() == 0) begin
        report_mismatch($sformatf("unexpected beat src=%0d nb=%0d found=%0b last=%0b",
                                  got.src, got.nb, got.found, got.last));
      end else begin
        want = expected_links.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "src %0d/%0d nb %0d/%0d found %0b/%0b last %0b/%0b (got/expected)",
            got.src, want.src, got.nb, want.nb, got.found, want.found,
            got.last, want.last));
        end
      end
    end
  end

  task automatic send_beat(input logic act, input logic [IDX_W-1:0] idx, input point_t pt);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    point_index_i <= idx;
    coord_x_i     <= pt.x;
    coord_y_i     <= pt.y;
    coord_z_i     <= pt.z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    find_neighbours(act, idx, pt);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_links.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [RAD_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_RADIUS) begin
      radius_copy = data;
    end else begin
      count_copy = data[CNT_W-1:0];
    end
  endtask

  task automatic test_radius_boundary();
    write_reg(REG_COUNT, 42'd6);
    send_beat(ACT_LOAD, 6'd0, mk_point(0, 0, 0));
    send_beat(ACT_LOAD, 6'd1, mk_point(256, 0, 0));
    send_beat(ACT_LOAD, 6'd2, mk_point(257, 0, 0));
    send_beat(ACT_LOAD, 6'd3, mk_point(0, -256, 0));
    send_beat(ACT_LOAD, 6'd4, mk_point(COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(ACT_LOAD, 6'd5, mk_point(COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(ACT_QUERY, 6'd0, random_point());
    send_beat(ACT_QUERY, 6'd2, random_point());
    send_beat(ACT_QUERY, 6'd4, random_point());
  endtask

  task automatic test_count_limits();
    wait_idle();
    write_reg(REG_COUNT, 42'd0);
    send_beat(ACT_QUERY, 6'd0, random_point());
    wait_idle();
    write_reg(REG_RADIUS, RADIUS_MAX);
    write_reg(REG_COUNT, 42'd6);
    send_beat(ACT_QUERY, 6'd5, random_point());
    wait_idle();
    write_reg(REG_COUNT, 42'd3);
    send_beat(ACT_QUERY, 6'd5, random_point());
  endtask

  task automatic test_overwrite();
    wait_idle();
    write_reg(REG_RADIUS, 42'd65536);
    write_reg(REG_COUNT, 42'd6);
    send_beat(ACT_LOAD, 6'd1, mk_point(-300000, 200000, 100000));
    send_beat(ACT_QUERY, 6'd0, random_point());
    send_beat(ACT_QUERY, 6'd1, random_point());
  endtask

  // Every entry is loaded here, so later queries may scan the whole store.
  task automatic test_store_fill();
    wait_idle();
    centre_x = int'($urandom_range(0, 1000000)) - 500000;
    centre_y = int'($urandom_range(0, 1000000)) - 500000;
    centre_z = int'($urandom_range(0, 1000000)) - 500000;
    for (int i = 0; i < POINTS; i++) begin
      send_beat(ACT_LOAD, IDX_W'(i), random_point());
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
    logic [RAD_W-1:0] radius;
    logic [RAD_W-1:0] count;
    int               pick;
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int blk = 0; blk < 4; blk++) begin
      wait_idle();
      centre_x = int'($urandom_range(0, 1000000)) - 500000;
      centre_y = int'($urandom_range(0, 1000000)) - 500000;
      centre_z = int'($urandom_range(0, 1000000)) - 500000;
      case ($urandom_range(3))
        0:       spread = 64;
        1:       spread = 256;
        2:       spread = 1024;
        default: spread = 4096;
      endcase
      case ($urandom_range(5))
        0:       radius = '0;
        1:       radius = 42'd65536;
        2:       radius = RAD_W'(longint'(spread) * spread * $urandom_range(1, 3));
        3:       radius = RAD_W'({$urandom(), $urandom()});
        4:       radius = RADIUS_MAX;
        default: radius = RAD_W'(longint'(spread) * spread / 4);
      endcase
      case ($urandom_range(5))
        0:       count = 42'd64;
        1:       count = 42'd127;
        2:       count = 42'd1;
        3:       count = 42'd0;
        default: count = RAD_W'($urandom_range(2, 64));
      endcase
      write_reg(REG_RADIUS, radius);
      write_reg(REG_COUNT, count);
      for (int i = 0; i < items / 4; i++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          wait_idle();
        end
        if (pick < 30) begin
          send_beat(ACT_LOAD, IDX_W'($urandom_range(0, POINTS - 1)), random_point());
        end else begin
          send_beat(ACT_QUERY, IDX_W'($urandom_range(0, POINTS - 1)), random_point());
        end
      end
    end
  endtask

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    send_gap_pct = 22;
    recv_gap_pct = 47;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_radius_boundary();
    test_count_limits();
    test_overwrite();
    test_store_fill();
    test_random_traffic(22, 47, 100);
    test_random_traffic(47, 22, 100);
    test_random_traffic(0, 0, 100);
    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
